>>> sv/assert_macros.svh
// Assertion macros shared by the pool RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define SLNF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define SLNF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/slnf_pkg.sv
// Package for the linked list pool: command codes, stream layout, item types.
// No dependencies.
package slnf_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_PUSH   = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;
  localparam logic [1:0] CMD_POP    = 2'd3;

  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 1;

  typedef struct packed {
    logic              is_insert;
    logic              at_back;
    logic              sel;
    logic [31:0]       value;
    logic [5:0]        position;
  } slnf_item_t;

  typedef struct packed {
    logic              ok;
    logic [4:0]        slot;
    logic [5:0]        list_size;
    logic [5:0]        free_slots;
  } slnf_result_t;

endpackage

>>> sv/static_linked_list_next_fit_pool_top.sv
// Channel  Ports        tdata (low bit up)            tuser (low bit up)
// in       in_t*        value[31:0] position[37:32]   cmd[1:0] list_select[2]
// out      out_t*       slot list_size free_slots     ok[0]
// A command leaves the queue, is decoded and loads the result register; an insert
// first runs a next-fit search that examines 1 to POOL_SLOTS slots, a position past
// the head adds a list walk plus link RAM updates (erase at the head reads the link RAM).
// A two-entry command queue keeps taking words until full while the back end works
// or the result register waits; reset is synchronous and clears lists and pool.
// Depends on slnf_pkg, slnf_front, slnf_back, slnf_ram, assert_macros.svh.
`include "assert_macros.svh"
module static_linked_list_next_fit_pool_top
  import slnf_pkg::*;
#(
  parameter int POOL_SLOTS = 32,
  parameter int NUM_LISTS  = 2,
  parameter int VALUE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value, position
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // cmd, list_select
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // slot, list_size, free_slots
  output logic [OUT_TUSER_W-1:0] out_tuser   // ok
);

  localparam int FW = $clog2(POOL_SLOTS + 1);

  logic                            q_valid, q_ready;
  slnf_item_t                      q_item;
  slnf_result_t                    res;
  logic [$clog2(POOL_SLOTS+1)-1:0] bk_free;
  logic [POOL_SLOTS-1:0]           bk_used;

  slnf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  slnf_back #(
    .POOL_SLOTS (POOL_SLOTS),
    .NUM_LISTS  (NUM_LISTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_data  (res),
    .free_o    (bk_free),
    .used_o    (bk_used)
  );

  assign out_tdata = {7'd0, res.free_slots, res.list_size, res.slot};
  assign out_tuser = res.ok;

  `SLNF_ASSERT(a_free_range, bk_free <= FW'(POOL_SLOTS), "free count beyond pool size")
  `SLNF_ASSERT(a_pool_count, $countones(bk_used) + int'(bk_free) == POOL_SLOTS, "pool mismatch")
  `SLNF_ASSERT_IMPL(a_reject_slot, out_tvalid && !res.ok, res.slot == '0, "slot set on reject")

endmodule

>>> sv/slnf_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module slnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/slnf_front.sv
// Command front end: unpacks and classifies stream words into a two-entry queue.
// Depends on slnf_pkg.
module slnf_front
  import slnf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [IN_TUSER_W-1:0] in_tuser,
  output logic                  q_valid,
  input  logic                  q_ready,
  output slnf_item_t            q_item
);

  slnf_item_t entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  slnf_item_t item;
  logic [1:0] cmd;

  assign cmd            = in_tuser[1:0];
  assign item.is_insert = (cmd == CMD_INSERT) || (cmd == CMD_PUSH);
  assign item.at_back   = (cmd == CMD_PUSH) || (cmd == CMD_POP);
  assign item.sel       = in_tuser[2];
  assign item.value     = in_tdata[31:0];
  assign item.position  = in_tdata[37:32];

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = entry_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= item;
    end
  end

endmodule

>>> sv/slnf_back.sv
// Command back end: next-fit slot allocation, list walks, link updates, result register.
// Depends on slnf_pkg and slnf_ram.
module slnf_back
  import slnf_pkg::*;
#(
  parameter int POOL_SLOTS = 32,
  parameter int NUM_LISTS  = 2,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  slnf_item_t                          q_item,
  output logic                                res_valid,
  input  logic                                res_ready,
  output slnf_result_t                        res_data,
  output logic [$clog2(POOL_SLOTS+1)-1:0]     free_o,
  output logic [POOL_SLOTS-1:0]               used_o
);

  localparam int SW  = $clog2(POOL_SLOTS);
  localparam int LW  = $clog2(POOL_SLOTS + 1);
  localparam int CW  = (LW > 6) ? LW : 6;
  localparam int LSW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam logic SEL1_OK = (NUM_LISTS > 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_ILINK = 4'd4;
  localparam logic [3:0] S_IFIX  = 4'd5;
  localparam logic [3:0] S_EDEL  = 4'd6;
  localparam logic [3:0] S_ENXT  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]            state_r, state_nxt;
  logic [SW-1:0]         scan_r, scan_nxt;
  logic [LW-1:0]         free_r, free_nxt;
  logic [POOL_SLOTS-1:0] used_r, used_nxt;
  logic [LW-1:0]         llen_r [NUM_LISTS];
  logic [LW-1:0]         llen_nxt [NUM_LISTS];
  logic [SW-1:0]         lhead_r [NUM_LISTS];
  logic [SW-1:0]         lhead_nxt [NUM_LISTS];
  logic                  out_valid_r, out_valid_nxt;
  logic                  pend_r, pend_nxt;

  logic                  ins_r, ins_nxt;
  logic                  back_r, back_nxt;
  logic                  sel_r, sel_nxt;
  logic                  vsel_r, vsel_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [CW-1:0]         epos_r, epos_nxt;
  logic [LW-1:0]         len_r, len_nxt;
  logic [SW-1:0]         head_r, head_nxt;
  logic [SW-1:0]         t_r, t_nxt;
  logic [SW-1:0]         prev_r, prev_nxt;
  logic [SW-1:0]         del_r, del_nxt;
  logic [SW-1:0]         cur_r, cur_nxt;
  logic [LW-1:0]         cnt_r, cnt_nxt;
  logic                  rok_r, rok_nxt;
  logic [SW-1:0]         rslot_r, rslot_nxt;
  slnf_result_t          out_r, out_nxt;

  logic                  lk_we;
  logic [SW-1:0]         lk_waddr, lk_wdata, lk_raddr, lk_rdata;
  logic                  vl_we;
  logic [SW-1:0]         vl_waddr;
  logic [SW-1:0]         walk_addr;
  logic [LSW-1:0]        lsel, qsel;
  logic [LW-1:0]         qlen;
  logic                  ins_rej, era_rej;

  slnf_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  slnf_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_SLOTS)) u_value_ram (
    .clk   (clk),
    .we    (vl_we),
    .waddr (vl_waddr),
    .wdata (val_r),
    .raddr ('0),
    .rdata ()
  );

  assign q_ready   = (state_r == S_IDLE);
  assign res_valid = out_valid_r;
  assign res_data  = out_r;
  assign free_o    = free_r;
  assign used_o    = used_r;

  assign walk_addr = pend_r ? lk_rdata : cur_r;
  assign lsel      = LSW'(sel_r);
  assign qsel      = LSW'(q_item.sel);
  assign qlen      = llen_r[qsel];
  assign ins_rej   = (len_r >= LW'(POOL_SLOTS)) || (epos_r > CW'(len_r)) || (free_r == '0);
  assign era_rej   = (back_r && (len_r == '0)) || (epos_r >= CW'(len_r));

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    free_nxt      = free_r;
    used_nxt      = used_r;
    llen_nxt      = llen_r;
    lhead_nxt     = lhead_r;
    out_valid_nxt = out_valid_r && !res_ready;
    pend_nxt      = pend_r;
    ins_nxt       = ins_r;
    back_nxt      = back_r;
    sel_nxt       = sel_r;
    vsel_nxt      = vsel_r;
    val_nxt       = val_r;
    epos_nxt      = epos_r;
    len_nxt       = len_r;
    head_nxt      = head_r;
    t_nxt         = t_r;
    prev_nxt      = prev_r;
    del_nxt       = del_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    rok_nxt       = rok_r;
    rslot_nxt     = rslot_r;
    out_nxt       = out_r;
    lk_we         = 1'b0;
    lk_waddr      = t_r;
    lk_wdata      = lk_rdata;
    lk_raddr      = walk_addr;
    vl_we         = 1'b0;
    vl_waddr      = scan_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          ins_nxt  = q_item.is_insert;
          back_nxt = q_item.at_back;
          sel_nxt  = q_item.sel;
          vsel_nxt = !q_item.sel || SEL1_OK;
          val_nxt  = VALUE_BITS'($unsigned(q_item.value));
          len_nxt  = qlen;
          head_nxt = lhead_r[qsel];
          if (!q_item.at_back) begin
            epos_nxt = CW'(q_item.position);
          end else if (q_item.is_insert) begin
            epos_nxt = CW'(qlen);
          end else begin
            epos_nxt = CW'(LW'(qlen - 1'b1));
          end
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!vsel_r || (ins_r ? ins_rej : era_rej)) begin
          rok_nxt   = 1'b0;
          rslot_nxt = '0;
          state_nxt = S_OUT;
        end else if (ins_r) begin
          state_nxt = S_SCAN;
        end else if (epos_r == '0) begin
          del_nxt   = head_r;
          lk_raddr  = head_r;
          state_nxt = S_ENXT;
        end else begin
          cur_nxt   = head_r;
          pend_nxt  = 1'b0;
          cnt_nxt   = LW'(epos_r - 1'b1);
          state_nxt = S_WALK;
        end
      end
      S_SCAN: begin
        if (used_r[scan_r]) begin
          scan_nxt = (scan_r == SW'(POOL_SLOTS - 1)) ? '0 : SW'(scan_r + 1'b1);
        end else begin
          t_nxt            = scan_r;
          used_nxt[scan_r] = 1'b1;
          free_nxt         = LW'(free_r - 1'b1);
          vl_we            = 1'b1;
          if (epos_r == '0) begin
            lk_we           = 1'b1;
            lk_waddr        = scan_r;
            lk_wdata        = (len_r != '0) ? head_r : '0;
            lhead_nxt[lsel] = scan_r;
            llen_nxt[lsel]  = LW'(len_r + 1'b1);
            rok_nxt         = 1'b1;
            rslot_nxt       = scan_r;
            state_nxt       = S_OUT;
          end else begin
            cur_nxt   = head_r;
            pend_nxt  = 1'b0;
            cnt_nxt   = LW'(epos_r - 1'b1);
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        lk_raddr = walk_addr;
        cur_nxt  = walk_addr;
        pend_nxt = 1'b1;
        if (cnt_r == '0) begin
          prev_nxt  = walk_addr;
          state_nxt = ins_r ? S_ILINK : S_EDEL;
        end else begin
          cnt_nxt = LW'(cnt_r - 1'b1);
        end
      end
      S_ILINK: begin
        lk_we     = 1'b1;
        lk_waddr  = t_r;
        lk_wdata  = lk_rdata;
        state_nxt = S_IFIX;
      end
      S_IFIX: begin
        lk_we          = 1'b1;
        lk_waddr       = prev_r;
        lk_wdata       = t_r;
        llen_nxt[lsel] = LW'(len_r + 1'b1);
        rok_nxt        = 1'b1;
        rslot_nxt      = t_r;
        state_nxt      = S_OUT;
      end
      S_EDEL: begin
        del_nxt   = lk_rdata;
        lk_raddr  = lk_rdata;
        state_nxt = S_ENXT;
      end
      S_ENXT: begin
        if (epos_r == '0) begin
          lhead_nxt[lsel] = lk_rdata;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = prev_r;
          lk_wdata = lk_rdata;
        end
        used_nxt[del_r] = 1'b0;
        free_nxt        = LW'(free_r + 1'b1);
        llen_nxt[lsel]  = LW'(len_r - 1'b1);
        rok_nxt         = 1'b1;
        rslot_nxt       = del_r;
        state_nxt       = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || res_ready) begin
          out_valid_nxt      = 1'b1;
          out_nxt.ok         = rok_r;
          out_nxt.slot       = 5'(rslot_r);
          out_nxt.list_size  = vsel_r ? 6'(llen_r[lsel]) : 6'd0;
          out_nxt.free_slots = 6'(free_r);
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= '0;
      free_r      <= LW'(POOL_SLOTS);
      used_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        llen_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      free_r      <= free_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      llen_r      <= llen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lhead_r <= lhead_nxt;
    ins_r   <= ins_nxt;
    back_r  <= back_nxt;
    sel_r   <= sel_nxt;
    vsel_r  <= vsel_nxt;
    val_r   <= val_nxt;
    epos_r  <= epos_nxt;
    len_r   <= len_nxt;
    head_r  <= head_nxt;
    t_r     <= t_nxt;
    prev_r  <= prev_nxt;
    del_r   <= del_nxt;
    cur_r   <= cur_nxt;
    cnt_r   <= cnt_nxt;
    rok_r   <= rok_nxt;
    rslot_r <= rslot_nxt;
    out_r   <= out_nxt;
  end

endmodule
